FILE: hw/rtl/bmon_pkg.sv
// shared types, constants and helper functions for the battery/temperature monitor
// no dependencies
`default_nettype none

package bmon_pkg;

	localparam int SMP_W     = 12;
	localparam int SUM_W     = 17;
	localparam int BAR_W     = 4;
	localparam int CFG_IDX_W = 2;
	localparam int IN_W      = 24;
	localparam int OUT_W     = 32;

	// divider operand widths: |normal - avg| and |step|
	localparam int QUO_W  = 12;
	localparam int STEP_W = 10;

	// floor(x / 21) == (x * AVG_MULT) >> AVG_SHIFT for every 17-bit x
	localparam int         AVG_SHIFT = 22;
	localparam logic [17:0] AVG_MULT = 18'd199729;
	// floor(x / 5) == (x * STEP_MULT) >> STEP_SHIFT for every 12-bit x
	localparam int         STEP_SHIFT = 14;
	localparam logic [11:0] STEP_MULT = 12'd3277;

	localparam logic [CFG_IDX_W-1:0] CFG_FAN_ON  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FAN_OFF = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BAT_CRIT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BAT_NORM = 2'd3;

	localparam logic [SMP_W-1:0] FAN_ON_RST   = 12'd1000;
	localparam logic [SMP_W-1:0] FAN_OFF_RST  = 12'd1500;
	localparam logic [SMP_W-1:0] BAT_CRIT_RST = 12'd2000;
	localparam logic [SMP_W-1:0] BAT_NORM_RST = 12'd3000;

	localparam logic [BAR_W-1:0] BAR_FULL  = 4'hF;
	localparam logic [BAR_W-1:0] BAR_DARK  = 4'h0;
	localparam logic [QUO_W-1:0] BAR_STEPS = 12'd5;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUM,
		ST_AVG_LOAD,
		ST_EVAL,
		ST_DIV_START,
		ST_DIV,
		ST_OUT
	} bmon_state_t;

	typedef struct packed {
		logic take;
		logic sum_add;
		logic avg_mul;
		logic avg_load;
		logic eval;
		logic div_start;
		logic out_load;
	} bmon_cmd_t;

	typedef struct packed {
		logic window_full;
		logic div_busy;
		logic out_free;
	} bmon_sts_t;

	function automatic logic [SMP_W-1:0] avg_sat(input logic [SMP_W:0] q);
		avg_sat = q[SMP_W] ? {SMP_W{1'b1}} : q[SMP_W-1:0];
	endfunction

	// lit = 5 - signed quotient, clamped to 0..4, as a thermometer code
	function automatic logic [BAR_W-1:0] bar_code(input logic [QUO_W-1:0] quo,
		input logic neg);
		logic [QUO_W-1:0] lit;
		lit = '0;
		if (quo == '0 || neg) begin
			bar_code = BAR_FULL;
		end else if (quo >= BAR_STEPS) begin
			bar_code = BAR_DARK;
		end else begin
			lit = BAR_STEPS - quo;
			case (lit[2:0])
				3'd1: bar_code = 4'h1;
				3'd2: bar_code = 4'h3;
				3'd3: bar_code = 4'h7;
				3'd4: bar_code = BAR_FULL;
				default: bar_code = BAR_DARK;
			endcase
		end
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/bmon_div.sv
// iterative unsigned restoring divider, one quotient bit per cycle
// depends on bmon_pkg
`default_nettype none

module bmon_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [bmon_pkg::QUO_W-1:0]  dividend,
	input  wire logic [bmon_pkg::STEP_W-1:0] divisor,
	output logic                            busy,
	output logic [bmon_pkg::QUO_W-1:0]       quotient
);
	import bmon_pkg::*;

	localparam int CNT_W = $clog2(QUO_W);

	logic              busy_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [STEP_W-1:0] rem_q;
	logic [STEP_W-1:0] dsr_q;
	logic [QUO_W-1:0]  quo_q;

	logic [STEP_W:0]   trial;
	logic [STEP_W+1:0] diff;
	logic              ge;

	assign trial = {rem_q, quo_q[QUO_W-1]};
	assign diff  = {1'b0, trial} - {2'b00, dsr_q};
	assign ge    = !diff[STEP_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (cnt_q == CNT_W'(QUO_W - 1)) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dsr_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[STEP_W-1:0] : trial[STEP_W-1:0];
			quo_q <= {quo_q[QUO_W-2:0], ge};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

FILE: hw/rtl/bmon_dp.sv
// datapath: config registers, window sums, averages, fan and bar evaluation, output register
// depends on bmon_pkg and bmon_div
`default_nettype none

module bmon_dp #(
	parameter int WINDOW_SAMPLES = 20
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [bmon_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [bmon_pkg::SMP_W-1:0]     cfg_wdata,
	input  wire logic [bmon_pkg::IN_W-1:0]      s_tdata,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [bmon_pkg::OUT_W-1:0]          m_tdata,
	input  wire bmon_pkg::bmon_cmd_t            cmd,
	output bmon_pkg::bmon_sts_t                 sts
);
	import bmon_pkg::*;

	localparam int CW = $clog2(WINDOW_SAMPLES + 1);
	localparam int AVG_PROD_W = SUM_W + 18;
	localparam int STEP_PROD_W = 2 * SMP_W;

	logic [SMP_W-1:0] fan_on_q, fan_off_q, crit_lvl_q, norm_lvl_q;

	logic [SMP_W-1:0] bsmp_q, tsmp_q;
	logic [SUM_W-1:0] bsum_q, tsum_q;
	logic [CW-1:0]    count_q;
	logic [AVG_PROD_W-1:0] bprod_q, tprod_q;
	logic [SMP_W-1:0] bavg_q, tavg_q;
	logic             upd_q, fan_q, crit_q;
	logic [STEP_PROD_W-1:0] step_prod_q;
	logic             step_neg_q, num_neg_q;
	logic             out_valid_q;
	logic [OUT_W-1:0] out_data_q;

	logic [SUM_W:0]   bsum_add, tsum_add;
	logic             fan_nxt;
	logic [SMP_W:0]   step_diff, num_diff;
	logic [SMP_W-1:0] step_abs, num_abs;
	logic [STEP_W-1:0] step_mag;
	logic             div_busy;
	logic [QUO_W-1:0] quo;
	logic [BAR_W-1:0] bar;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fan_on_q   <= FAN_ON_RST;
			fan_off_q  <= FAN_OFF_RST;
			crit_lvl_q <= BAT_CRIT_RST;
			norm_lvl_q <= BAT_NORM_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FAN_ON:   fan_on_q   <= cfg_wdata;
				CFG_FAN_OFF:  fan_off_q  <= cfg_wdata;
				CFG_BAT_CRIT: crit_lvl_q <= cfg_wdata;
				CFG_BAT_NORM: norm_lvl_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign bsum_add = {1'b0, bsum_q} + (SUM_W+1)'(bsmp_q);
	assign tsum_add = {1'b0, tsum_q} + (SUM_W+1)'(tsmp_q);

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			bsmp_q <= s_tdata[SMP_W-1:0];
			tsmp_q <= s_tdata[2*SMP_W-1:SMP_W];
		end
		if (cmd.avg_mul) begin
			bprod_q <= AVG_PROD_W'(bsum_q) * AVG_PROD_W'(AVG_MULT);
			tprod_q <= AVG_PROD_W'(tsum_q) * AVG_PROD_W'(AVG_MULT);
		end
		if (cmd.eval) begin
			step_neg_q  <= step_diff[SMP_W];
			step_prod_q <= STEP_PROD_W'(step_abs) * STEP_PROD_W'(STEP_MULT);
		end
		if (cmd.div_start) begin
			num_neg_q <= num_diff[SMP_W];
		end
	end

	// window sums and averages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bsum_q  <= '0;
			tsum_q  <= '0;
			count_q <= '0;
			bavg_q  <= '0;
			tavg_q  <= '0;
			upd_q   <= 1'b0;
		end else if (cmd.sum_add) begin
			bsum_q  <= bsum_add[SUM_W] ? {SUM_W{1'b1}} : bsum_add[SUM_W-1:0];
			tsum_q  <= tsum_add[SUM_W] ? {SUM_W{1'b1}} : tsum_add[SUM_W-1:0];
			count_q <= count_q + 1'b1;
			upd_q   <= 1'b0;
		end else if (cmd.avg_load) begin
			bavg_q  <= avg_sat(bprod_q[AVG_SHIFT+SMP_W:AVG_SHIFT]);
			tavg_q  <= avg_sat(tprod_q[AVG_SHIFT+SMP_W:AVG_SHIFT]);
			bsum_q  <= '0;
			tsum_q  <= '0;
			count_q <= '0;
			upd_q   <= 1'b1;
		end
	end

	// fan hysteresis: switch-on test first, switch-off test on the result
	always_comb begin
		fan_nxt = fan_q;
		if (tavg_q < fan_on_q && !fan_nxt) begin
			fan_nxt = 1'b1;
		end
		if (tavg_q > fan_off_q && fan_nxt) begin
			fan_nxt = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fan_q  <= 1'b0;
			crit_q <= 1'b0;
		end else if (cmd.eval) begin
			fan_q  <= fan_nxt;
			crit_q <= bavg_q < crit_lvl_q;
		end
	end

	// bar step and numerator, sign and magnitude
	assign step_diff = {1'b0, norm_lvl_q} - {1'b0, crit_lvl_q};
	assign step_abs  = step_diff[SMP_W] ? SMP_W'(-step_diff) : step_diff[SMP_W-1:0];
	assign step_mag  = step_prod_q[STEP_SHIFT+STEP_W-1:STEP_SHIFT];
	assign num_diff  = {1'b0, norm_lvl_q} - {1'b0, bavg_q};
	assign num_abs   = num_diff[SMP_W] ? SMP_W'(-num_diff) : num_diff[SMP_W-1:0];

	bmon_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (num_abs),
		.divisor  (step_mag),
		.busy     (div_busy),
		.quotient (quo)
	);

	always_comb begin
		if (crit_q) begin
			bar = BAR_DARK;
		end else if (step_mag == '0) begin
			bar = BAR_FULL;
		end else begin
			bar = bar_code(quo, num_neg_q ^ step_neg_q);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_data_q <= {1'b0, bar, crit_q, fan_q, upd_q, tavg_q, bavg_q};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	assign sts.window_full = count_q >= CW'(WINDOW_SAMPLES);
	assign sts.div_busy    = div_busy;
	assign sts.out_free    = !out_valid_q || m_tready;

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(WINDOW_SAMPLES))
		else $error("window count past window length");
	a_avg_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.avg_load |=> count_q == '0 && bsum_q == '0 && tsum_q == '0 && upd_q)
		else $error("window not cleared after average load");
	a_add_no_upd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sum_add |=> !upd_q && count_q == $past(count_q) + 1'b1)
		else $error("summing item flagged as update");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/bmon_ctrl.sv
// controller state machine sequencing one transaction through the datapath
// depends on bmon_pkg
`default_nettype none

module bmon_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire bmon_pkg::bmon_sts_t sts,
	output bmon_pkg::bmon_cmd_t      cmd
);
	import bmon_pkg::*;

	bmon_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		cmd      = '0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.take = 1'b1;
					state_d  = ST_SUM;
				end
			end
			ST_SUM: begin
				if (sts.window_full) begin
					cmd.avg_mul = 1'b1;
					state_d     = ST_AVG_LOAD;
				end else begin
					cmd.sum_add = 1'b1;
					state_d     = ST_EVAL;
				end
			end
			ST_AVG_LOAD: begin
				cmd.avg_load = 1'b1;
				state_d      = ST_EVAL;
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = ST_DIV_START;
			end
			ST_DIV_START: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DIV;
			end
			ST_DIV: begin
				if (!sts.div_busy) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

`ifndef SYNTHESIS
	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take |=> state_q == ST_SUM && !s_tready)
		else $error("transaction accepted without entering sum state");
	a_load_after_mul: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.avg_load |-> $past(cmd.avg_mul))
		else $error("average load without preceding multiply");
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !sts.div_busy)
		else $error("divider started while busy");
	a_out_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> s_tready)
		else $error("not ready after result load");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/battery_temp_monitor_fan_ledbar.sv
// sequence: a transaction accepted in ST_IDLE passes through ST_SUM, ST_AVG_LOAD when
// it closes a window (for the average load), ST_EVAL, ST_DIV_START and ST_DIV for the
// bar divider, then ST_OUT, which waits while the result slot stays full and m_tready is low
// a new transaction is taken only after the last one's result is loaded;
// the output register holds a result while the next is taken
// reset: async active low, clears sums, averages, fan and critical flags, loads levels
`default_nettype none

module battery_temp_monitor_fan_ledbar #(
	parameter int WINDOW_SAMPLES = 20
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [bmon_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [bmon_pkg::SMP_W-1:0]     cfg_wdata,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// battery_sample[11:0], temperature_sample[23:12]
	input  wire logic [bmon_pkg::IN_W-1:0]      s_tdata,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// battery_average[11:0], temperature_average[23:12], average_updated[24],
	// fan_enable[25], critical_power[26], battery_bar[30:27], zero[31]
	output logic [bmon_pkg::OUT_W-1:0]          m_tdata
);
	import bmon_pkg::*;

	bmon_cmd_t cmd;
	bmon_sts_t sts;

	bmon_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bmon_dp #(
		.WINDOW_SAMPLES (WINDOW_SAMPLES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

`default_nettype wire

FILE: bench/tb_battery_temp_monitor_fan_ledbar.sv
`timescale 1ns / 100ps
// testbench for battery_temp_monitor_fan_ledbar: streams sample pairs under several level
// settings, predicts averages, fan flag, critical flag and battery bar, checks every result
// depends on bmon_pkg and the battery_temp_monitor_fan_ledbar rtl

module tb_battery_temp_monitor_fan_ledbar;
	import bmon_pkg::*;

	localparam int WINDOW       = 20;
	localparam int AVG_DIV      = 21;
	localparam int SUM_CAP      = 131071;
	localparam int SMP_MAX      = 4095;
	localparam int BAR_SEGMENTS = 5;
	localparam int PHASE_ITEMS  = 128;

	typedef struct packed {
		logic             zero;
		logic [BAR_W-1:0] bar;
		logic             critical;
		logic             fan;
		logic             updated;
		logic [SMP_W-1:0] temp_avg;
		logic [SMP_W-1:0] batt_avg;
	} readout_t;

	class readout_tracker;
		logic [SMP_W-1:0] levels[4];
		int               batt_sum, temp_sum, count;
		logic [SMP_W-1:0] batt_avg, temp_avg;
		bit               fan_on;
		readout_t         pending[$];
		int               faults, checked, refreshes, fan_results, critical_results;

		function new();
			levels[CFG_FAN_ON]   = FAN_ON_RST;
			levels[CFG_FAN_OFF]  = FAN_OFF_RST;
			levels[CFG_BAT_CRIT] = BAT_CRIT_RST;
			levels[CFG_BAT_NORM] = BAT_NORM_RST;
			batt_sum = 0;
			temp_sum = 0;
			count = 0;
			batt_avg = '0;
			temp_avg = '0;
			fan_on = 1'b0;
			faults = 0;
			checked = 0;
			refreshes = 0;
			fan_results = 0;
			critical_results = 0;
		endfunction

		function logic [BAR_W-1:0] bar_level(int avg);
			int normal, crit, step, lit;
			normal = int'(levels[CFG_BAT_NORM]);
			crit = int'(levels[CFG_BAT_CRIT]);
			step = (normal - crit) / BAR_SEGMENTS;
			if (step == 0)
				return BAR_FULL;
			lit = BAR_SEGMENTS - (normal - avg) / step;
			if (lit < 0)
				lit = 0;
			if (lit > 4)
				lit = 4;
			return BAR_W'((1 << lit) - 1);
		endfunction

		function readout_t predict_readout(logic [SMP_W-1:0] b, logic [SMP_W-1:0] t);
			readout_t r;
			r = '0;
			if (count < WINDOW) begin
				batt_sum = (batt_sum + int'(b) > SUM_CAP) ? SUM_CAP : batt_sum + int'(b);
				temp_sum = (temp_sum + int'(t) > SUM_CAP) ? SUM_CAP : temp_sum + int'(t);
				count++;
			end else begin
				batt_avg = (batt_sum / AVG_DIV > SMP_MAX) ? '1 : SMP_W'(batt_sum / AVG_DIV);
				temp_avg = (temp_sum / AVG_DIV > SMP_MAX) ? '1 : SMP_W'(temp_sum / AVG_DIV);
				batt_sum = 0;
				temp_sum = 0;
				count = 0;
				r.updated = 1'b1;
				refreshes++;
			end
			if (temp_avg < levels[CFG_FAN_ON] && !fan_on)
				fan_on = 1'b1;
			if (temp_avg > levels[CFG_FAN_OFF] && fan_on)
				fan_on = 1'b0;
			if (batt_avg < levels[CFG_BAT_CRIT]) begin
				r.critical = 1'b1;
				r.bar = BAR_DARK;
				critical_results++;
			end else begin
				r.bar = bar_level(int'(batt_avg));
			end
			r.fan = fan_on;
			fan_results += fan_on;
			r.batt_avg = batt_avg;
			r.temp_avg = temp_avg;
			return r;
		endfunction

		function void note_sample(logic [SMP_W-1:0] b, logic [SMP_W-1:0] t);
			pending.push_back(predict_readout(b, t));
		endfunction

		function void check_readout(readout_t got);
			readout_t want;
			bit bad;
			if (pending.size() == 0) begin
				faults++;
				if (faults <= 10)
					$display("%0t: result %h with nothing expected", $realtime, got);
				return;
			end
			want = pending.pop_front();
			checked++;
			bad = got.batt_avg !== want.batt_avg || got.temp_avg !== want.temp_avg ||
				got.updated !== want.updated || got.fan !== want.fan ||
				got.critical !== want.critical || got.bar !== want.bar ||
				got.zero !== want.zero;
			if (bad) begin
				faults++;
				if (faults <= 10) begin
					$display("%0t: result %0d expected batt %0d temp %0d upd %b fan %b crit %b bar %b",
						$realtime, checked, want.batt_avg, want.temp_avg, want.updated,
						want.fan, want.critical, want.bar);
					$display("%0t: result %0d actual   batt %0d temp %0d upd %b fan %b crit %b bar %b",
						$realtime, checked, got.batt_avg, got.temp_avg, got.updated,
						got.fan, got.critical, got.bar);
				end
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [SMP_W-1:0]     cfg_wdata = '0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	// battery_sample[11:0], temperature_sample[23:12]
	logic [IN_W-1:0]      s_tdata = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	// battery_average[11:0], temperature_average[23:12], average_updated[24],
	// fan_enable[25], critical_power[26], battery_bar[30:27], zero[31]
	logic [OUT_W-1:0]     m_tdata;

	readout_tracker tracker = new();
	bit calm = 1'b0;
	int items_sent = 0;
	int settings_used = 1;

	battery_temp_monitor_fan_ledbar #(.WINDOW_SAMPLES(WINDOW)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			tracker.check_readout(readout_t'(m_tdata));
	end

	function automatic logic [SMP_W-1:0] clamp_sample(int v);
		if (v < 0)
			return '0;
		if (v > SMP_MAX)
			return '1;
		return SMP_W'(v);
	endfunction

	// window center near one of two levels, between them, or anywhere
	function automatic int pick_center(int lo_lvl, int hi_lvl);
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, SMP_MAX);
			1: return lo_lvl * AVG_DIV / WINDOW + int'($urandom_range(0, 160)) - 80;
			2: return hi_lvl * AVG_DIV / WINDOW + int'($urandom_range(0, 160)) - 80;
			default: return (lo_lvl + hi_lvl) / 2 * AVG_DIV / WINDOW +
				int'($urandom_range(0, 800)) - 400;
		endcase
	endfunction

	task automatic send_pair(input logic [SMP_W-1:0] b, input logic [SMP_W-1:0] t);
		s_tvalid <= 1'b1;
		s_tdata <= {t, b};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		tracker.note_sample(b, t);
		items_sent++;
		if (!calm && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
	endtask

	task automatic drain;
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (tracker.pending.size() != 0)
			@(posedge clk);
		repeat (24) @(posedge clk);
	endtask

	task automatic program_levels(input logic [SMP_W-1:0] on_lvl, input logic [SMP_W-1:0] off_lvl,
		input logic [SMP_W-1:0] crit_lvl, input logic [SMP_W-1:0] norm_lvl);
		logic [SMP_W-1:0]     vals[4];
		logic [CFG_IDX_W-1:0] idx[4];
		vals = '{on_lvl, off_lvl, crit_lvl, norm_lvl};
		idx = '{CFG_FAN_ON, CFG_FAN_OFF, CFG_BAT_CRIT, CFG_BAT_NORM};
		for (int i = 0; i < 4; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= idx[i];
			cfg_wdata <= vals[i];
			@(posedge clk);
			tracker.levels[idx[i]] = vals[i];
		end
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	task automatic run_samples(input int n);
		int batt_center, temp_center;
		batt_center = 0;
		temp_center = 0;
		for (int i = 0; i < n; i++) begin
			if (i % AVG_DIV == 0) begin
				batt_center = pick_center(int'(tracker.levels[CFG_BAT_CRIT]),
					int'(tracker.levels[CFG_BAT_NORM]));
				temp_center = pick_center(int'(tracker.levels[CFG_FAN_ON]),
					int'(tracker.levels[CFG_FAN_OFF]));
			end
			if ($urandom_range(0, 7) == 0)
				send_pair(SMP_W'($urandom), SMP_W'($urandom));
			else
				send_pair(clamp_sample(batt_center + int'($urandom_range(0, 128)) - 64),
					clamp_sample(temp_center + int'($urandom_range(0, 128)) - 64));
		end
	endtask

	initial begin
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (!calm && $urandom_range(0, 2) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 40)) @(posedge clk);
		end
	end

	initial begin
		#5_000_000;
		$display("tb: failure");
		$finish;
	end

	initial begin
		logic [SMP_W-1:0] settings[9][4];
		settings = '{
			'{12'd0, 12'd0, 12'd0, 12'd0},
			'{12'd4095, 12'd4095, 12'd4095, 12'd4095},
			'{12'd3000, 12'd1000, 12'd2000, 12'd3000},
			'{12'd1000, 12'd1500, 12'd3000, 12'd1000},
			'{12'd1200, 12'd1800, 12'd2000, 12'd2004},
			'{12'd0, 12'd4095, 12'd1000, 12'd1010},
			'{12'd2000, 12'd2000, 12'd0, 12'd4095},
			'{SMP_W'($urandom), SMP_W'($urandom), SMP_W'($urandom), SMP_W'($urandom)},
			'{FAN_ON_RST, FAN_OFF_RST, BAT_CRIT_RST, BAT_NORM_RST}
		};
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// defaults: field extremes, then a full window and its refresh
		send_pair('0, '0);
		send_pair('1, '1);
		send_pair(12'hAAA, 12'h555);
		send_pair(12'h555, 12'hAAA);
		repeat (17) send_pair('1, '0);
		send_pair(12'h800, 12'h001);
		send_pair(12'h001, 12'h800);
		run_samples(PHASE_ITEMS);
		drain();

		for (int p = 0; p < 9; p++) begin
			program_levels(settings[p][0], settings[p][1], settings[p][2], settings[p][3]);
			if (p == 8)
				calm = 1'b1;
			run_samples(PHASE_ITEMS);
			drain();
		end

		$display("covered %0d sample pairs under %0d level settings, %0d results checked",
			items_sent, settings_used, tracker.checked);
		$display("%0d average refreshes, fan running in %0d results, critical power in %0d",
			tracker.refreshes, tracker.fan_results, tracker.critical_results);
		if (tracker.faults == 0 && tracker.pending.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
